// ----- sv/lpt_pkg.sv -----
package lpt_pkg;

  // Store geometry and field widths
  localparam int MaxSamples = 1024;
  localparam int IdxW       = $clog2(MaxSamples);
  localparam int CntW       = 11;
  localparam int LatW       = 31;
  localparam int PctW       = 7;
  localparam int CfgIdxW    = 2;
  localparam int NumPct     = 3;
  localparam int KW         = 2;

  // Percentile register indexes
  localparam logic [CfgIdxW-1:0] CfgFirst  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSecond = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgThird  = 2'd2;

  // Percentile reset points
  localparam logic [PctW-1:0] PctFirstReset  = 7'd50;
  localparam logic [PctW-1:0] PctSecondReset = 7'd95;
  localparam logic [PctW-1:0] PctThirdReset  = 7'd99;

  // Division by the percent scale is a multiply by a slightly low reciprocal
  // (5242 / 2^19) followed by a single upward correction.
  localparam int PctScale   = 100;
  localparam int ProdW      = CntW + PctW;
  localparam int RecipW     = 13;
  localparam int RecipShift = 19;
  localparam int MulW       = ProdW + RecipW;
  localparam int QW         = MulW - RecipShift;
  localparam logic [RecipW-1:0] RecipMul = 13'd5242;

  typedef struct packed {
    logic            start;
    logic [CntW-1:0] n;
    logic [PctW-1:0] p;
  } rank_req_t;

  typedef struct packed {
    logic            done;
    logic [IdxW-1:0] idx;
  } rank_rsp_t;

endpackage

// ----- sv/lpt_ram.sv -----
module lpt_ram #(
  parameter int Depth = 1024,
  parameter int Width = 31
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/lpt_rank.sv -----
module lpt_rank import lpt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  rank_req_t req,
  output rank_rsp_t rsp
);

  logic             v1;
  logic             v2;
  logic [ProdW-1:0] prod;
  logic [ProdW-1:0] prod2;
  logic [QW-1:0]    q_est;
  logic [CntW-1:0]  n1;
  logic [CntW-1:0]  n2;
  logic [MulW-1:0]  mul;
  logic [ProdW-1:0] rem;
  logic [QW-1:0]    rank;
  logic [QW-1:0]    idx_raw;
  logic [CntW-1:0]  n_dec;
  logic [IdxW-1:0]  idx_next;

  // Quotient estimate from the reciprocal product.
  assign mul = MulW'(prod) * MulW'(RecipMul);

  // Correct the estimate, turn the rank into an index and clamp it.
  always_comb begin
    rem     = prod2 - ProdW'(q_est) * ProdW'(PctScale);
    rank    = (rem >= ProdW'(PctScale)) ? q_est + QW'(1) : q_est;
    idx_raw = (rank == '0) ? '0 : rank - QW'(1);
    n_dec   = n2 - CntW'(1);
    if (idx_raw > QW'(n_dec)) begin
      idx_next = n_dec[IdxW-1:0];
    end else begin
      idx_next = idx_raw[IdxW-1:0];
    end
  end

  // Three stages: rounded product, quotient estimate, corrected index.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      v1       <= req.start;
      v2       <= v1;
      rsp.done <= v2;
    end
    prod    <= ProdW'(req.n) * ProdW'(req.p) + ProdW'(PctScale - 1);
    n1      <= req.n;
    prod2   <= prod;
    n2      <= n1;
    q_est   <= mul[MulW-1:RecipShift];
    rsp.idx <= idx_next;
  end

endmodule

// ----- sv/latency_percentile_tracker_core.sv -----
// Latency percentile tracker with a sorted sample store in a single-port-pair RAM.
// Sequence: a clear transfer goes straight to the output register; a sample transfer first
// is inserted into the sorted store (skipped when the store is full, the sample then not kept):
// insertion shifts one entry per cycle, then min, max and three rank lookups.
// Throughput: one item at a time; the next transfer can be taken once the result is
// registered. Reset (sync, active high) clears counts and flag, points to 50/95/99; RAM kept.
module latency_percentile_tracker_core import lpt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                clear_all,
  input  logic                accepted,
  input  logic signed [31:0]  latency_ns,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         received_count,
  output logic [31:0]         accepted_count,
  output logic [31:0]         rejected_count,
  output logic [CntW-1:0]     samples_held,
  output logic [LatW-1:0]     min_latency,
  output logic [LatW-1:0]     max_latency,
  output logic [LatW-1:0]     first_quantile,
  output logic [LatW-1:0]     second_quantile,
  output logic [LatW-1:0]     third_quantile,
  output logic                store_full,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [PctW-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    IDLE, INS_SCAN, INS_PUT, RD_MIN, CAP_MIN, CAP_MAX, Q_START, Q_WAIT, Q_CAP, DONE
  } state_t;

  state_t          state;
  logic [IdxW-1:0] pos;
  logic [LatW-1:0] lat_v;
  logic [KW-1:0]   k;
  logic [CntW-1:0] sample_total;
  logic [31:0]     received_total;
  logic [31:0]     accepted_total;
  logic [31:0]     rejected_total;
  logic            overflow_seen;
  logic [PctW-1:0] pct [NumPct];
  logic [LatW-1:0] min_w;
  logic [LatW-1:0] max_w;
  logic [LatW-1:0] q_w [NumPct];

  logic            in_fire;
  logic [LatW-1:0] lat_clamped;
  logic [CntW-1:0] n_dec;
  logic [IdxW-1:0] pos_dec;
  logic [IdxW-1:0] pos_dec2;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [LatW-1:0] wr_data;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic [LatW-1:0] rd_data;
  rank_req_t       rank_req;
  rank_rsp_t       rank_rsp;

  assign in_ready    = (state == IDLE);
  assign cfg_ready   = 1'b1;
  assign in_fire     = in_valid && in_ready;
  assign lat_clamped = latency_ns[31] ? '0 : LatW'(latency_ns[30:0]);
  assign n_dec       = sample_total - CntW'(1);
  assign pos_dec     = pos - IdxW'(1);
  assign pos_dec2    = pos - IdxW'(2);

  assign rank_req.start = (state == Q_START);
  assign rank_req.n     = sample_total;
  assign rank_req.p     = pct[k];

  lpt_ram #(.Depth(MaxSamples), .Width(LatW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lpt_rank u_rank (
    .clk (clk),
    .rst (rst),
    .req (rank_req),
    .rsp (rank_rsp)
  );

  // RAM port control. While scanning, the write at pos and the read at pos-2
  // never touch the same entry.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = lat_v;
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state)
      IDLE: begin
        if (in_fire && !clear_all && sample_total != CntW'(MaxSamples) &&
            sample_total != '0) begin
          rd_en   = 1'b1;
          rd_addr = n_dec[IdxW-1:0];
        end
      end
      INS_SCAN: begin
        wr_en = 1'b1;
        if (rd_data > lat_v) begin
          wr_data = rd_data;
          if (pos_dec != '0) begin
            rd_en   = 1'b1;
            rd_addr = pos_dec2;
          end
        end
      end
      INS_PUT: begin
        wr_en = 1'b1;
      end
      RD_MIN: begin
        rd_en = 1'b1;
      end
      CAP_MIN: begin
        rd_en   = 1'b1;
        rd_addr = n_dec[IdxW-1:0];
      end
      Q_WAIT: begin
        if (rank_rsp.done) begin
          rd_en   = 1'b1;
          rd_addr = rank_rsp.idx;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer, counters, percentile registers and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      k              <= '0;
      sample_total   <= '0;
      received_total <= '0;
      accepted_total <= '0;
      rejected_total <= '0;
      overflow_seen  <= 1'b0;
      pct[0]         <= PctFirstReset;
      pct[1]         <= PctSecondReset;
      pct[2]         <= PctThirdReset;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CfgFirst:  pct[0] <= cfg_data;
          CfgSecond: pct[1] <= cfg_data;
          CfgThird:  pct[2] <= cfg_data;
          default: begin
          end
        endcase
      end

      // A taken result empties the register unless a new one is loaded this cycle.
      if (out_valid && out_ready && state != DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (in_fire) begin
            if (clear_all) begin
              sample_total   <= '0;
              received_total <= '0;
              accepted_total <= '0;
              rejected_total <= '0;
              overflow_seen  <= 1'b0;
              min_w          <= '0;
              max_w          <= '0;
              q_w[0]         <= '0;
              q_w[1]         <= '0;
              q_w[2]         <= '0;
              state          <= DONE;
            end else begin
              if (received_total != '1) begin
                received_total <= received_total + 32'd1;
              end
              if (accepted) begin
                if (accepted_total != '1) begin
                  accepted_total <= accepted_total + 32'd1;
                end
              end else if (rejected_total != '1) begin
                rejected_total <= rejected_total + 32'd1;
              end
              lat_v <= lat_clamped;
              pos   <= sample_total[IdxW-1:0];
              if (sample_total == CntW'(MaxSamples)) begin
                overflow_seen <= 1'b1;
                state         <= RD_MIN;
              end else begin
                sample_total <= sample_total + CntW'(1);
                state        <= (sample_total == '0) ? INS_PUT : INS_SCAN;
              end
            end
          end
        end
        INS_SCAN: begin
          if (rd_data > lat_v) begin
            pos   <= pos_dec;
            state <= (pos_dec == '0) ? INS_PUT : INS_SCAN;
          end else begin
            state <= RD_MIN;
          end
        end
        INS_PUT: begin
          state <= RD_MIN;
        end
        RD_MIN: begin
          state <= CAP_MIN;
        end
        CAP_MIN: begin
          min_w <= rd_data;
          state <= CAP_MAX;
        end
        CAP_MAX: begin
          max_w <= rd_data;
          k     <= '0;
          state <= Q_START;
        end
        Q_START: begin
          state <= Q_WAIT;
        end
        Q_WAIT: begin
          if (rank_rsp.done) begin
            state <= Q_CAP;
          end
        end
        Q_CAP: begin
          q_w[k] <= rd_data;
          if (k == KW'(NumPct - 1)) begin
            k     <= '0;
            state <= DONE;
          end else begin
            k     <= k + KW'(1);
            state <= Q_START;
          end
        end
        DONE: begin
          // Hand over once the output register is free or being emptied.
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            received_count  <= received_total;
            accepted_count  <= accepted_total;
            rejected_count  <= rejected_total;
            samples_held    <= sample_total;
            min_latency     <= min_w;
            max_latency     <= max_w;
            first_quantile  <= q_w[0];
            second_quantile <= q_w[1];
            third_quantile  <= q_w[2];
            store_full      <= overflow_seen;
            state           <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/lpt_checker.sv -----
module lpt_checker import lpt_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [31:0]     received_count,
  input logic [CntW-1:0] samples_held,
  input logic [LatW-1:0] min_latency,
  input logic [LatW-1:0] max_latency,
  input logic [LatW-1:0] first_quantile,
  input logic            store_full
);

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(received_count))
    else $error("result changed while stalled");

  // Items are worked one at a time: no transfer in the cycle after one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  // The full flag only shows with a full store.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && store_full |-> samples_held == CntW'(MaxSamples))
    else $error("full flag with a store that is not full");

  // An empty store reports zeros.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && samples_held == '0 |->
      min_latency == '0 && max_latency == '0 && first_quantile == '0)
    else $error("empty store reports a non-zero latency");

  // The first quantile lies between the minimum and the maximum of the sorted store.
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> min_latency <= first_quantile && first_quantile <= max_latency)
    else $error("quantile outside minimum and maximum");

endmodule

bind latency_percentile_tracker_core lpt_checker u_lpt_checker (.*);
